/* src/sptu_pkg.sv */
// Shared widths, register indexes, angle constants and the CORDIC arctangent table.
package sptu_pkg;

    localparam int ANG_W = 31;
    localparam int RED_W = 26;
    localparam int CS_W  = 32;
    localparam int NUM_W = 56;
    localparam int DEN_W = 32;
    localparam int QUO_W = NUM_W + 1;
    localparam int CFG_W = 24;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_BASELINE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_TILT        = 3'd1;
    localparam logic [IDX_W-1:0] REG_CONVERGENCE = 3'd2;
    localparam logic [IDX_W-1:0] REG_RIGHT_X     = 3'd3;
    localparam logic [IDX_W-1:0] REG_RIGHT_Y     = 3'd4;
    localparam logic [IDX_W-1:0] REG_LEFT_X      = 3'd5;
    localparam logic [IDX_W-1:0] REG_HALF_HEIGHT = 3'd6;

    localparam logic [23:0]        RST_BASELINE    = 24'd91095;
    localparam logic signed [23:0] RST_TILT        = 24'sd0;
    localparam logic signed [23:0] RST_CONVERGENCE = 24'sd0;
    localparam logic [19:0]        RST_RIGHT_X     = 20'd57470;
    localparam logic [19:0]        RST_RIGHT_Y     = 20'd55668;
    localparam logic [19:0]        RST_LEFT_X      = 20'd57470;
    localparam logic [11:0]        RST_HALF_HEIGHT = 12'd540;

    // Degrees in Q.16: a full turn is 360 * 2^16 = 45 * 2^19.
    localparam logic signed [RED_W-1:0] DEG_FULL    = 26'sd23592960;
    localparam logic signed [RED_W-1:0] DEG_HALF    = 26'sd11796480;
    localparam logic signed [RED_W-1:0] DEG_QUARTER = 26'sd5898240;
    // Forty-six whole turns, enough to make any input angle non-negative.
    localparam logic [31:0] WRAP_OFFSET = 32'd1085276160;
    localparam logic [10:0] RECIP_45    = 11'd1456;
    localparam logic [6:0]  TURN_DIV    = 7'd45;

    localparam logic signed [CS_W-1:0]  CORDIC_GAIN  = 32'sd652032874;
    localparam logic signed [63:0]      MOUNT_HEIGHT = 64'sd98304;
    localparam logic signed [QUO_W-1:0] DIV_BIG      = 57'sh80000000000000;

    function automatic logic signed [RED_W-1:0] atan_entry(input int unsigned idx);
        logic signed [RED_W-1:0] val;
        case (idx)
            0: val = 26'sd2949120;
            1: val = 26'sd1740967;
            2: val = 26'sd919879;
            3: val = 26'sd466945;
            4: val = 26'sd234379;
            5: val = 26'sd117304;
            6: val = 26'sd58666;
            7: val = 26'sd29335;
            8: val = 26'sd14668;
            9: val = 26'sd7334;
            10: val = 26'sd3667;
            11: val = 26'sd1833;
            12: val = 26'sd917;
            13: val = 26'sd458;
            14: val = 26'sd229;
            15: val = 26'sd115;
            16: val = 26'sd57;
            17: val = 26'sd29;
            18: val = 26'sd14;
            19: val = 26'sd7;
            20: val = 26'sd4;
            21: val = 26'sd2;
            22: val = 26'sd1;
            default: val = 26'sd0;
        endcase
        return val;
    endfunction

endpackage

/* src/stereo_point_triangulation_unit.sv */
// Top level of the stereo triangulation pipeline: registers, angle setup, products, dividers, output.
// One matched pixel pair enters per clock while s_ready is high and one X, Y, Z word leaves per clock while
// m_ready is high, in order. The path from input to output word runs through pixel-to-angle conversion,
// angle reduction and CORDIC rotation, Q2.30 products and baseline scaling, the bit-per-stage dividers,
// summing and saturation, and the output register.
// A two-entry output buffer lets the
// pipeline keep taking words while a finished word waits; the input stalls only when both are full.
// Configuration writes take effect at once and are meant to be made while the pipeline is empty.
module stereo_point_triangulation_unit #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [11:0]                  s_right_col,
    input  logic signed [11:0]                  s_right_row,
    input  logic signed [11:0]                  s_left_col,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [31:0]                  m_pos_x,
    output logic signed [31:0]                  m_pos_y,
    output logic signed [31:0]                  m_pos_z,
    output logic                                m_degenerate,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sptu_pkg::IDX_W-1:0]          cfg_index,
    input  logic [sptu_pkg::CFG_W-1:0]          cfg_data
);
    import sptu_pkg::*;

    localparam int SC_LAT  = CORDIC_STEPS + 5;
    localparam int DIV_LAT = NUM_W + 2;
    localparam int SIDE_N  = 8 + SC_LAT + DIV_LAT;

    typedef struct packed {
        logic valid;
        logic zsel;
    } side_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               deg;
    } word_t;

    function automatic logic signed [ANG_W-1:0] to_deg(input logic [31:0] prod,
                                                       input logic neg);
        logic [32:0]             rnd;
        logic signed [ANG_W-1:0] mag;
        rnd = 33'(prod) + 33'd8;
        mag = signed'({2'b00, rnd[32:4]});
        return neg ? -mag : mag;
    endfunction

    function automatic logic signed [CS_W-1:0] round_q30(input logic signed [63:0] p);
        logic signed [63:0] sum;
        sum = p + 64'sd536870912;
        return sum[61:30];
    endfunction

    function automatic logic signed [NUM_W-1:0] scale_base(input logic [23:0] b,
                                                           input logic signed [CS_W-1:0] q);
        logic signed [56:0] prod;
        prod = 57'(signed'({1'b0, b})) * 57'(q);
        return prod[NUM_W-1:0];
    endfunction

    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] res;
        if (v > 64'sd2147483647) begin
            res = {1'b1, 32'h7fffffff};
        end else if (v < -64'sd2147483648) begin
            res = {1'b1, 32'h80000000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    // Configuration registers.
    logic [23:0]        baseline_reg;
    logic signed [23:0] tilt_reg;
    logic signed [23:0] conv_reg;
    logic [19:0]        rxs_reg;
    logic [19:0]        rys_reg;
    logic [19:0]        lxs_reg;
    logic [11:0]        hh_reg;

    logic en;
    side_t side_reg [0:SIDE_N-1];

    // Pixel stage.
    logic [11:0]        rc_mag;
    logic [11:0]        rr_mag;
    logic [11:0]        lc_mag;
    logic               zsel;
    logic [31:0]        rc_prod_reg;
    logic [31:0]        rr_prod_reg;
    logic [31:0]        lc_prod_reg;
    logic               rc_neg_reg;
    logic               rr_neg_reg;
    logic               lc_neg_reg;

    // Angle stage.
    logic signed [ANG_W-1:0] dr;
    logic signed [ANG_W-1:0] dl;
    logic signed [ANG_W-1:0] a1_reg;
    logic signed [ANG_W-1:0] a2_reg;
    logic signed [ANG_W-1:0] ag_reg;
    logic signed [ANG_W-1:0] bt_reg;
    logic signed [ANG_W-1:0] tilt_ang;

    logic signed [CS_W-1:0] s1;
    logic signed [CS_W-1:0] s2;
    logic signed [CS_W-1:0] c2;
    logic signed [CS_W-1:0] sg;
    logic signed [CS_W-1:0] st;
    logic signed [CS_W-1:0] ct;
    logic signed [CS_W-1:0] sb;
    logic signed [CS_W-1:0] cb;

    // Product stages.
    logic signed [63:0]      pr1_reg;
    logic signed [63:0]      pr2_reg;
    logic signed [63:0]      pr3_reg;
    logic signed [63:0]      pr4_reg;
    logic signed [63:0]      pr5_reg;
    logic signed [CS_W-1:0]  sb_m1_reg;
    logic signed [CS_W-1:0]  sg_m1_reg;
    logic signed [CS_W-1:0]  q1_reg;
    logic signed [CS_W-1:0]  q2_reg;
    logic signed [CS_W-1:0]  q3_reg;
    logic signed [CS_W-1:0]  q4_reg;
    logic signed [CS_W-1:0]  q5_m2_reg;
    logic signed [CS_W-1:0]  sb_m2_reg;
    logic signed [CS_W-1:0]  sg_m2_reg;
    logic signed [NUM_W-1:0] n1_m3_reg;
    logic signed [NUM_W-1:0] n2_m3_reg;
    logic signed [NUM_W-1:0] n3_m3_reg;
    logic signed [63:0]      pr6_reg;
    logic signed [CS_W-1:0]  sg_m3_reg;
    logic signed [CS_W-1:0]  q5_m3_reg;
    logic signed [NUM_W-1:0] n1_m4_reg;
    logic signed [NUM_W-1:0] n2_m4_reg;
    logic signed [NUM_W-1:0] n3_m4_reg;
    logic signed [CS_W-1:0]  q6_reg;
    logic signed [CS_W-1:0]  sg_m4_reg;
    logic signed [CS_W-1:0]  q5_m4_reg;
    logic signed [NUM_W-1:0] n1_m5_reg;
    logic signed [NUM_W-1:0] n2_m5_reg;
    logic signed [NUM_W-1:0] n3_m5_reg;
    logic signed [NUM_W-1:0] n4_m5_reg;
    logic signed [CS_W-1:0]  sg_m5_reg;
    logic signed [CS_W-1:0]  q5_m5_reg;

    // Divider results.
    logic signed [QUO_W-1:0] px_q;
    logic signed [QUO_W-1:0] py_q;
    logic signed [QUO_W-1:0] h11_q;
    logic signed [QUO_W-1:0] h1_q;
    logic                    px_zero;
    logic                    py_zero;
    logic                    h11_zero;
    logic                    h1_zero;

    // Final stages.
    logic signed [63:0] px_f1_reg;
    logic signed [63:0] py_f1_reg;
    logic signed [63:0] pz_f1_reg;
    logic               zero_f1_reg;
    logic signed [63:0] pz_sum;
    logic [32:0]        sat_x;
    logic [32:0]        sat_y;
    logic [32:0]        sat_z;
    word_t              f2_reg;
    logic               f2_valid_reg;

    word_t out_reg;
    word_t skid_reg;
    logic  out_valid_reg;
    logic  skid_valid_reg;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg <= RST_BASELINE;
            tilt_reg <= RST_TILT;
            conv_reg <= RST_CONVERGENCE;
            rxs_reg <= RST_RIGHT_X;
            rys_reg <= RST_RIGHT_Y;
            lxs_reg <= RST_LEFT_X;
            hh_reg <= RST_HALF_HEIGHT;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BASELINE:    baseline_reg <= cfg_data;
                REG_TILT:        tilt_reg <= signed'(cfg_data);
                REG_CONVERGENCE: conv_reg <= signed'(cfg_data);
                REG_RIGHT_X:     rxs_reg <= cfg_data[19:0];
                REG_RIGHT_Y:     rys_reg <= cfg_data[19:0];
                REG_LEFT_X:      lxs_reg <= cfg_data[19:0];
                REG_HALF_HEIGHT: hh_reg <= cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline moves together; it halts only while the output buffer is full.
    assign en = !skid_valid_reg;
    assign s_ready = en && aresetn;

    always_comb begin
        rc_mag = s_right_col[11] ? unsigned'(-s_right_col) : unsigned'(s_right_col);
        rr_mag = s_right_row[11] ? unsigned'(-s_right_row) : unsigned'(s_right_row);
        lc_mag = s_left_col[11] ? unsigned'(-s_left_col) : unsigned'(s_left_col);
        zsel = signed'({s_right_row[11], s_right_row}) <= signed'({1'b0, hh_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SIDE_N; k++) begin
                side_reg[k] <= '0;
            end
        end else if (en) begin
            side_reg[0] <= '{valid: s_valid, zsel: zsel};
            for (int k = 1; k < SIDE_N; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_comb begin
        dr = to_deg(rc_prod_reg, rc_neg_reg);
        dl = to_deg(lc_prod_reg, lc_neg_reg);
        tilt_ang = ANG_W'(tilt_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rc_prod_reg <= 32'(rc_mag) * 32'(rxs_reg);
            rr_prod_reg <= 32'(rr_mag) * 32'(rys_reg);
            lc_prod_reg <= 32'(lc_mag) * 32'(lxs_reg);
            rc_neg_reg <= s_right_col[11];
            rr_neg_reg <= s_right_row[11];
            lc_neg_reg <= s_left_col[11];

            a1_reg <= ANG_W'(conv_reg) + dr;
            a2_reg <= ANG_W'(conv_reg) - dl;
            ag_reg <= ANG_W'(conv_reg) + ANG_W'(conv_reg) + dr - dl;
            bt_reg <= to_deg(rr_prod_reg, rr_neg_reg);
        end
    end

    sptu_sincos #(.STEPS(CORDIC_STEPS)) u_sc_a1 (
        .aclk(aclk), .en(en), .angle(a1_reg), .sin_out(s1), .cos_out()
    );
    sptu_sincos #(.STEPS(CORDIC_STEPS)) u_sc_a2 (
        .aclk(aclk), .en(en), .angle(a2_reg), .sin_out(s2), .cos_out(c2)
    );
    sptu_sincos #(.STEPS(CORDIC_STEPS)) u_sc_gamma (
        .aclk(aclk), .en(en), .angle(ag_reg), .sin_out(sg), .cos_out()
    );
    sptu_sincos #(.STEPS(CORDIC_STEPS)) u_sc_tilt (
        .aclk(aclk), .en(en), .angle(tilt_ang), .sin_out(st), .cos_out(ct)
    );
    sptu_sincos #(.STEPS(CORDIC_STEPS)) u_sc_beta (
        .aclk(aclk), .en(en), .angle(bt_reg), .sin_out(sb), .cos_out(cb)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            pr1_reg <= 64'(s1) * 64'(c2);
            pr2_reg <= 64'(s1) * 64'(s2);
            pr3_reg <= 64'(s2) * 64'(st);
            pr4_reg <= 64'(s2) * 64'(ct);
            pr5_reg <= 64'(cb) * 64'(sg);
            sb_m1_reg <= sb;
            sg_m1_reg <= sg;

            q1_reg <= round_q30(pr1_reg);
            q2_reg <= round_q30(pr2_reg);
            q3_reg <= round_q30(pr3_reg);
            q4_reg <= round_q30(pr4_reg);
            q5_m2_reg <= round_q30(pr5_reg);
            sb_m2_reg <= sb_m1_reg;
            sg_m2_reg <= sg_m1_reg;

            n1_m3_reg <= scale_base(baseline_reg, q1_reg);
            n2_m3_reg <= scale_base(baseline_reg, q2_reg);
            n3_m3_reg <= scale_base(baseline_reg, q3_reg);
            pr6_reg <= 64'(q4_reg) * 64'(sb_m2_reg);
            sg_m3_reg <= sg_m2_reg;
            q5_m3_reg <= q5_m2_reg;

            n1_m4_reg <= n1_m3_reg;
            n2_m4_reg <= n2_m3_reg;
            n3_m4_reg <= n3_m3_reg;
            q6_reg <= round_q30(pr6_reg);
            sg_m4_reg <= sg_m3_reg;
            q5_m4_reg <= q5_m3_reg;

            n1_m5_reg <= n1_m4_reg;
            n2_m5_reg <= n2_m4_reg;
            n3_m5_reg <= n3_m4_reg;
            n4_m5_reg <= scale_base(baseline_reg, q6_reg);
            sg_m5_reg <= sg_m4_reg;
            q5_m5_reg <= q5_m4_reg;
        end
    end

    sptu_div u_div_x (
        .aclk(aclk), .en(en), .num(n1_m5_reg), .den(sg_m5_reg), .quo(px_q), .zero(px_zero)
    );
    sptu_div u_div_y (
        .aclk(aclk), .en(en), .num(n2_m5_reg), .den(sg_m5_reg), .quo(py_q), .zero(py_zero)
    );
    sptu_div u_div_h11 (
        .aclk(aclk), .en(en), .num(n3_m5_reg), .den(sg_m5_reg), .quo(h11_q), .zero(h11_zero)
    );
    sptu_div u_div_h1 (
        .aclk(aclk), .en(en), .num(n4_m5_reg), .den(q5_m5_reg), .quo(h1_q), .zero(h1_zero)
    );

    always_comb begin
        if (side_reg[SIDE_N-2].zsel) begin
            pz_sum = MOUNT_HEIGHT + 64'(h11_q) + 64'(h1_q);
        end else begin
            pz_sum = MOUNT_HEIGHT + 64'(h11_q) - 64'(h1_q);
        end
        sat_x = sat32(px_f1_reg);
        sat_y = sat32(py_f1_reg);
        sat_z = sat32(pz_f1_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_f1_reg <= 64'(px_q);
            py_f1_reg <= 64'(py_q);
            pz_f1_reg <= pz_sum;
            zero_f1_reg <= px_zero | py_zero | h11_zero | h1_zero;

            f2_reg.x <= signed'(sat_x[31:0]);
            f2_reg.y <= signed'(sat_y[31:0]);
            f2_reg.z <= signed'(sat_z[31:0]);
            f2_reg.deg <= zero_f1_reg | sat_x[32] | sat_y[32] | sat_z[32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f2_valid_reg <= 1'b0;
        end else if (en) begin
            f2_valid_reg <= side_reg[SIDE_N-1].valid;
        end
    end

    // Output register plus one skid entry; the last pipeline stage is taken whenever it moves.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= f2_valid_reg;
            out_reg <= f2_reg;
        end else if (f2_valid_reg) begin
            skid_valid_reg <= 1'b1;
            skid_reg <= f2_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_pos_x = out_reg.x;
    assign m_pos_y = out_reg.y;
    assign m_pos_z = out_reg.z;
    assign m_degenerate = out_reg.deg;

endmodule

/* src/sptu_sincos.sv */
// Pipelined sine and cosine of a Q.16 degree angle: modulo-360 reduction, then one CORDIC step per stage.
module sptu_sincos #(
    parameter int STEPS = 24
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [sptu_pkg::ANG_W-1:0]   angle,
    output logic signed [sptu_pkg::CS_W-1:0]    sin_out,
    output logic signed [sptu_pkg::CS_W-1:0]    cos_out
);
    import sptu_pkg::*;

    typedef struct packed {
        logic signed [CS_W-1:0]  x;
        logic signed [CS_W-1:0]  y;
        logic signed [RED_W-1:0] r;
        logic                    neg;
    } rot_t;

    logic [31:0]             wrap_reg;
    logic [12:0]             turn_reg;
    logic [18:0]             frac_reg;
    logic [7:0]              qest_reg;
    logic [24:0]             red_reg;
    rot_t                    rot_reg [0:STEPS];
    logic signed [CS_W-1:0]  sin_reg;
    logic signed [CS_W-1:0]  cos_reg;

    logic [23:0]             qprod;
    logic [13:0]             rem_wide;
    logic [6:0]              rem_raw;
    logic [5:0]              rem_fix;
    logic signed [RED_W-1:0] half_val;
    rot_t                    rot_first;

    always_comb begin
        // The turn count is the top bits over 45; the estimate is low by at most one.
        qprod = 24'(wrap_reg[31:19]) * 24'(RECIP_45);
        rem_wide = 14'(turn_reg) - 14'(qest_reg) * 14'(TURN_DIV);
        rem_raw = rem_wide[6:0];
        rem_fix = (rem_raw >= TURN_DIV) ? 6'(rem_raw - TURN_DIV) : rem_raw[5:0];

        half_val = signed'({1'b0, red_reg});
        if (half_val > DEG_HALF) begin
            half_val = half_val - DEG_FULL;
        end
        rot_first.x = CORDIC_GAIN;
        rot_first.y = '0;
        rot_first.r = half_val;
        rot_first.neg = 1'b0;
        if (half_val > DEG_QUARTER) begin
            rot_first.r = half_val - DEG_HALF;
            rot_first.neg = 1'b1;
        end else if (half_val < -DEG_QUARTER) begin
            rot_first.r = half_val + DEG_HALF;
            rot_first.neg = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wrap_reg <= unsigned'(32'(angle)) + WRAP_OFFSET;
            turn_reg <= wrap_reg[31:19];
            frac_reg <= wrap_reg[18:0];
            qest_reg <= qprod[23:16];
            red_reg <= {rem_fix, frac_reg};
            rot_reg[0] <= rot_first;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        rot_t rot_next;

        always_comb begin
            rot_next = rot_reg[i];
            if (rot_reg[i].r >= 0) begin
                rot_next.x = rot_reg[i].x - (rot_reg[i].y >>> i);
                rot_next.y = rot_reg[i].y + (rot_reg[i].x >>> i);
                rot_next.r = rot_reg[i].r - atan_entry(i);
            end else begin
                rot_next.x = rot_reg[i].x + (rot_reg[i].y >>> i);
                rot_next.y = rot_reg[i].y - (rot_reg[i].x >>> i);
                rot_next.r = rot_reg[i].r + atan_entry(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rot_reg[i+1] <= rot_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= rot_reg[STEPS].neg ? -rot_reg[STEPS].y : rot_reg[STEPS].y;
            cos_reg <= rot_reg[STEPS].neg ? -rot_reg[STEPS].x : rot_reg[STEPS].x;
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

/* src/sptu_div.sv */
// Pipelined signed divider, one quotient bit per stage, truncating toward zero with a zero-divisor clamp.
module sptu_div (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [sptu_pkg::NUM_W-1:0]   num,
    input  logic signed [sptu_pkg::DEN_W-1:0]   den,
    output logic signed [sptu_pkg::QUO_W-1:0]   quo,
    output logic                                zero
);
    import sptu_pkg::*;

    typedef struct packed {
        logic [DEN_W:0]   rem;
        logic [NUM_W-1:0] acc;
        logic [DEN_W-1:0] dmag;
        logic             neg;
        logic             zf;
        logic             nz;
    } step_t;

    step_t                   stg_reg [0:NUM_W];
    step_t                   stg_in;
    logic signed [QUO_W-1:0] quo_reg;
    logic                    zero_reg;
    logic signed [QUO_W-1:0] quo_next;

    always_comb begin
        stg_in.rem = '0;
        stg_in.acc = num[NUM_W-1] ? unsigned'(-num) : unsigned'(num);
        stg_in.dmag = den[DEN_W-1] ? unsigned'(-den) : unsigned'(den);
        stg_in.zf = (den == '0);
        stg_in.nz = (num != '0);
        // With a zero divisor the clamp follows the numerator's sign alone.
        stg_in.neg = (den == '0) ? num[NUM_W-1] : (num[NUM_W-1] ^ den[DEN_W-1]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stg_reg[0] <= stg_in;
        end
    end

    for (genvar i = 0; i < NUM_W; i++) begin : g_bit
        step_t          stg_next;
        logic [DEN_W:0]   shifted;
        logic [DEN_W+1:0] diff;

        always_comb begin
            stg_next = stg_reg[i];
            shifted = {stg_reg[i].rem[DEN_W-1:0], stg_reg[i].acc[NUM_W-1]};
            diff = {1'b0, shifted} - {2'b00, stg_reg[i].dmag};
            if (!diff[DEN_W+1]) begin
                stg_next.rem = diff[DEN_W:0];
                stg_next.acc = {stg_reg[i].acc[NUM_W-2:0], 1'b1};
            end else begin
                stg_next.rem = shifted;
                stg_next.acc = {stg_reg[i].acc[NUM_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stg_reg[i+1] <= stg_next;
            end
        end
    end

    always_comb begin
        if (stg_reg[NUM_W].zf) begin
            if (!stg_reg[NUM_W].nz) begin
                quo_next = '0;
            end else begin
                quo_next = stg_reg[NUM_W].neg ? -DIV_BIG : DIV_BIG;
            end
        end else if (stg_reg[NUM_W].neg) begin
            quo_next = -signed'({1'b0, stg_reg[NUM_W].acc});
        end else begin
            quo_next = signed'({1'b0, stg_reg[NUM_W].acc});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= quo_next;
            zero_reg <= stg_reg[NUM_W].zf;
        end
    end

    assign quo = quo_reg;
    assign zero = zero_reg;

endmodule
